/* hw/rtl/urb_pkg.sv */
// Package: depths, widths, command codes and state encoding for the UART ring buffer engine.
`default_nettype none
package urb_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;

  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

  localparam int BYTE_W   = 8;
  localparam int CMD_W    = 2;
  localparam int LEVEL_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_UART = 2'd0,
    CMD_READ = 2'd1,
    CMD_LOAD = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/uart_ring_buffers_with_tx_enable.sv */
// Top level: receive ring, transmit packet buffer and line driver enable for a half-duplex UART.
//
// At acceptance of a request the receive and transmit memories are read at the current read
// pointer and send pointer; in the execute state the item is applied, the memories are
// written back and the result is loaded into the output register. The next request is taken
// only after that, back in idle, so the block does not take a new request before the last
// one is through. A stalled output holds the block in its execute state.
// Both memories come out of reset with undefined contents and need no clearing pass.
`default_nettype none
module uart_ring_buffers_with_tx_enable
  import urb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic              in_rx_ready,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  input  wire logic              in_tx_reg_empty,
  input  wire logic              in_tx_line_done,
  input  wire logic [BYTE_W-1:0] in_load_byte,
  input  wire logic              in_load_first,

  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [BYTE_W-1:0] out_read_byte,
  output      logic [LEVEL_W-1:0] out_rx_level,
  output      logic              out_send_valid,
  output      logic [BYTE_W-1:0] out_send_byte,
  output      logic              out_drive_enable,
  output      logic              out_tx_idle
);

  state_t              state_r, state_nxt;

  logic [CMD_W-1:0]    cmd_r;
  logic                rx_ready_r;
  logic [BYTE_W-1:0]   rx_byte_r;
  logic                tx_reg_empty_r;
  logic                tx_line_done_r;
  logic [BYTE_W-1:0]   load_byte_r;
  logic                load_first_r;

  logic [RX_AW-1:0]    rx_wptr_r, rx_wptr_nxt;
  logic [RX_AW-1:0]    rx_rptr_r, rx_rptr_nxt;
  logic [RX_CNT_W-1:0] rx_count_r, rx_count_nxt;
  logic [TX_CNT_W-1:0] tx_fill_r, tx_fill_nxt;
  logic [TX_CNT_W-1:0] tx_next_r, tx_next_nxt;
  logic                driver_on_r, driver_on_nxt;
  logic                tx_empty_r, tx_empty_nxt;

  logic [BYTE_W-1:0]   rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0]   tx_mem [TX_DEPTH];
  logic [BYTE_W-1:0]   rx_rdata_r;
  logic [BYTE_W-1:0]   tx_rdata_r;

  logic                in_accept;
  logic                exec_go;
  logic                rx_push, rx_pop;
  logic                tx_we;
  logic [TX_CNT_W-1:0] tx_base;
  logic                send;

  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_read_byte_r;
  logic [LEVEL_W-1:0]  out_rx_level_r;
  logic                out_send_valid_r;
  logic [BYTE_W-1:0]   out_send_byte_r;
  logic                out_drive_enable_r;
  logic                out_tx_idle_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign exec_go   = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_EXEC;
      ST_EXEC: if (exec_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rx_push       = (cmd_r == CMD_UART) && rx_ready_r
                    && (rx_count_r < RX_CNT_W'(RX_DEPTH));
    rx_pop        = (cmd_r == CMD_READ) && (rx_count_r != '0);
    rx_wptr_nxt   = rx_wptr_r;
    rx_rptr_nxt   = rx_rptr_r;
    rx_count_nxt  = rx_count_r;
    tx_fill_nxt   = tx_fill_r;
    tx_next_nxt   = tx_next_r;
    driver_on_nxt = driver_on_r;
    tx_empty_nxt  = tx_empty_r;
    tx_we         = 1'b0;
    tx_base       = load_first_r ? '0 : tx_fill_r;
    send          = 1'b0;

    if (rx_push) begin
      rx_wptr_nxt  = (rx_wptr_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wptr_r + 1'b1;
      rx_count_nxt = rx_count_r + 1'b1;
    end
    if (rx_pop) begin
      rx_rptr_nxt  = (rx_rptr_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rptr_r + 1'b1;
      rx_count_nxt = rx_count_r - 1'b1;
    end

    case (cmd_r)
      CMD_UART: begin
        if (tx_next_r < tx_fill_r) begin
          driver_on_nxt = 1'b1;
          tx_empty_nxt  = 1'b0;
          if (tx_reg_empty_r) begin
            send        = 1'b1;
            tx_next_nxt = tx_next_r + 1'b1;
          end
        end else begin
          tx_empty_nxt = 1'b1;
          if (tx_line_done_r) driver_on_nxt = 1'b0;
        end
      end
      CMD_LOAD: begin
        if (load_first_r) tx_next_nxt = '0;
        tx_fill_nxt = tx_base;
        if (tx_base < TX_CNT_W'(TX_DEPTH)) begin
          tx_we       = 1'b1;
          tx_fill_nxt = tx_base + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rx_rdata_r <= rx_mem[rx_rptr_r];
      tx_rdata_r <= tx_mem[tx_next_r[TX_AW-1:0]];
    end
    if (exec_go && rx_push) rx_mem[rx_wptr_r] <= rx_byte_r;
    if (exec_go && tx_we) tx_mem[tx_base[TX_AW-1:0]] <= load_byte_r;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r          <= in_cmd;
      rx_ready_r     <= in_rx_ready;
      rx_byte_r      <= in_rx_byte;
      tx_reg_empty_r <= in_tx_reg_empty;
      tx_line_done_r <= in_tx_line_done;
      load_byte_r    <= in_load_byte;
      load_first_r   <= in_load_first;
    end
    if (exec_go) begin
      out_read_byte_r    <= rx_pop ? rx_rdata_r : '0;
      out_rx_level_r     <= LEVEL_W'(rx_count_nxt);
      out_send_valid_r   <= send;
      out_send_byte_r    <= send ? tx_rdata_r : '0;
      out_drive_enable_r <= driver_on_nxt;
      out_tx_idle_r      <= tx_empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rx_wptr_r   <= '0;
      rx_rptr_r   <= '0;
      rx_count_r  <= '0;
      tx_fill_r   <= '0;
      tx_next_r   <= '0;
      driver_on_r <= 1'b0;
      tx_empty_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        out_valid_r <= 1'b1;
        rx_wptr_r   <= rx_wptr_nxt;
        rx_rptr_r   <= rx_rptr_nxt;
        rx_count_r  <= rx_count_nxt;
        tx_fill_r   <= tx_fill_nxt;
        tx_next_r   <= tx_next_nxt;
        driver_on_r <= driver_on_nxt;
        tx_empty_r  <= tx_empty_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_byte    = out_read_byte_r;
  assign out_rx_level     = out_rx_level_r;
  assign out_send_valid   = out_send_valid_r;
  assign out_send_byte    = out_send_byte_r;
  assign out_drive_enable = out_drive_enable_r;
  assign out_tx_idle      = out_tx_idle_r;

  a_rx_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_count_r <= RX_CNT_W'(RX_DEPTH))
    else $error("receive count above ring depth");

  a_tx_next_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_next_r <= tx_fill_r)
    else $error("send pointer passed fill level");

  a_send_drives: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_valid |-> out_drive_enable && !out_tx_idle)
    else $error("byte sent with driver off or buffer idle");

  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid && state_r == ST_IDLE)
    else $error("completed request did not reach output register");

endmodule
`default_nettype wire
